// ===== rtl/lfpd_pkg.sv =====
package lfpd_pkg;

  localparam int unsigned FRAME_BYTES      = 47;
  localparam int unsigned POINTS_PER_FRAME = 12;
  localparam int unsigned WIN_AW           = $clog2(FRAME_BYTES);

  // frame layout offsets
  localparam logic [WIN_AW-1:0] OFS_HEADER = WIN_AW'(0);
  localparam logic [WIN_AW-1:0] OFS_LENGTH = WIN_AW'(1);
  localparam logic [WIN_AW-1:0] OFS_SPEED  = WIN_AW'(2);
  localparam logic [WIN_AW-1:0] OFS_START  = WIN_AW'(4);
  localparam logic [WIN_AW-1:0] OFS_POINT0 = WIN_AW'(6);
  localparam logic [WIN_AW-1:0] OFS_END    = WIN_AW'(42);
  localparam logic [WIN_AW-1:0] OFS_STAMP  = WIN_AW'(44);
  localparam logic [WIN_AW-1:0] OFS_CRC    = WIN_AW'(46);

  localparam logic [16:0] FULL_TURN   = 17'd36000;
  localparam logic [7:0]  CRC_POLY    = 8'h4D;
  // floor(2^24 / 11), quotient lands one low at most
  localparam logic [20:0] RECIP_11    = 21'd1525201;
  localparam int unsigned RECIP_SHIFT = 24;

  // configuration register indexes
  localparam logic [7:0] REG_HEADER    = 8'd0;
  localparam logic [7:0] REG_LENGTH    = 8'd1;
  localparam logic [7:0] REG_THRESHOLD = 8'd2;
  localparam logic [7:0] REG_PPR       = 8'd3;

  localparam logic [7:0] HEADER_RST    = 8'd84;
  localparam logic [7:0] LENGTH_RST    = 8'd44;
  localparam logic [7:0] THRESHOLD_RST = 8'd20;
  localparam logic [9:0] PPR_RST       = 10'd720;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== rtl/lidar_frame_point_decoder.sv =====
// Lidar frame decoder. Serial bytes enter on s_axis and collect in a 47-byte
// circular window held in a single-port-read RAM. A byte that does not fill
// the window is simply written to it. The byte that fills it starts a check:
// one RAM read per cycle walks the window through a byte-wide CRC-8 step,
// the CHECK state decides, and a valid frame then yields 12 points, each
// from three RAM reads plus a shared reciprocal multiply for the angle
// interpolation. The points wait whenever m_axis stalls.
// A failed check drops the oldest byte and returns to taking bytes. Each
// point leaves as one m_axis transfer; tlast marks the twelfth point and
// tuser flags the point on which the revolution slot counter wrapped.
module lidar_frame_point_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i,
  // byte stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  // point stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // point_angle[15:0], point_distance[31:16], point_confidence[39:32],
  // slot_index[49:40], rotor_speed[65:50], frame_time[81:66], zero[87:82]
  output logic [87:0] m_axis_tdata,
  output logic        m_axis_tlast,   // frame_last
  output logic [0:0]  m_axis_tuser    // revolution_done
);

  localparam int unsigned AW = lfpd_pkg::WIN_AW;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;
  localparam logic [1:0] ST_POINT = 2'd3;

  localparam logic [AW-1:0] LAST_BYTE = AW'(lfpd_pkg::FRAME_BYTES - 1);
  localparam logic [AW:0]   SCAN_END  = (AW+1)'(lfpd_pkg::FRAME_BYTES);
  localparam logic [3:0]    LAST_PT   = 4'(lfpd_pkg::POINTS_PER_FRAME - 1);

  function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
                                               input logic [AW:0]   ofs);
    logic [AW+1:0] s;
    s = {2'b00, base} + {1'b0, ofs};
    if (s >= (AW+2)'(lfpd_pkg::FRAME_BYTES)) begin
      s = s - (AW+2)'(lfpd_pkg::FRAME_BYTES);
    end
    return s[AW-1:0];
  endfunction

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] count_q, count_d;
  logic [AW:0]   idx_q, idx_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [1:0]    ph_q, ph_d;
  logic [3:0]    m_q, m_d;
  logic [7:0]    crc_q, crc_d;
  logic          hdr_ok_q, hdr_ok_d;
  logic          len_ok_q, len_ok_d;
  logic [7:0]    crc_byte_q, crc_byte_d;
  logic [15:0]   speed_q, speed_d;
  logic [15:0]   start_q, start_d;
  logic [15:0]   end_q, end_d;
  logic [15:0]   stamp_q, stamp_d;
  logic [16:0]   diff_q, diff_d;
  logic          span_neg_q, span_neg_d;
  logic [20:0]   numer_q, numer_d;
  logic [16:0]   q0_q, q0_d;
  logic [16:0]   quo_q, quo_d;
  logic [7:0]    dlo_q, dlo_d;
  logic [7:0]    dhi_q, dhi_d;
  logic [15:0]   ang_q, ang_d;
  logic          wrapped_q, wrapped_d;
  logic [9:0]    slot_q, slot_d;

  logic [7:0]    header_q, length_q, thr_q;
  logic [9:0]    ppr_q;

  logic          out_valid_q, out_valid_d;
  logic [87:0]   out_data_q, out_data_d;
  logic          out_last_q, out_last_d;
  logic          out_user_q, out_user_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;

  lfpd_ram #(
    .WIDTH (8),
    .DEPTH (lfpd_pkg::FRAME_BYTES)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (s_axis_tdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= lfpd_pkg::HEADER_RST;
      length_q <= lfpd_pkg::LENGTH_RST;
      thr_q    <= lfpd_pkg::THRESHOLD_RST;
      ppr_q    <= lfpd_pkg::PPR_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lfpd_pkg::REG_HEADER:    header_q <= cfg_data_i[7:0];
        lfpd_pkg::REG_LENGTH:    length_q <= cfg_data_i[7:0];
        lfpd_pkg::REG_THRESHOLD: thr_q    <= cfg_data_i[7:0];
        lfpd_pkg::REG_PPR:       ppr_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [AW-1:0] proc_idx;
  logic [41:0]   prod;
  logic [20:0]   q0_x11;
  logic [20:0]   rem;
  logic [17:0]   ang_sum;
  logic [16:0]   end_adj;
  logic [10:0]   slot_next;
  logic [15:0]   pt_dist;
  logic          keep;
  logic          out_free;
  logic          frame_ok;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    ph_d       = ph_q;
    m_d        = m_q;
    crc_d      = crc_q;
    hdr_ok_d   = hdr_ok_q;
    len_ok_d   = len_ok_q;
    crc_byte_d = crc_byte_q;
    speed_d    = speed_q;
    start_d    = start_q;
    end_d      = end_q;
    stamp_d    = stamp_q;
    diff_d     = diff_q;
    span_neg_d = span_neg_q;
    numer_d    = numer_q;
    q0_d       = q0_q;
    quo_d      = quo_q;
    dlo_d      = dlo_q;
    dhi_d      = dhi_q;
    ang_d      = ang_q;
    wrapped_d  = wrapped_q;
    slot_d     = slot_q;

    out_free    = !out_valid_q || m_axis_tready;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_user_d  = out_user_q;

    ram_we    = 1'b0;
    ram_waddr = wrap_addr(head_q, {1'b0, count_q});
    ram_raddr = wrap_addr(head_q, idx_q);

    proc_idx  = idx_q[AW-1:0] - AW'(1);
    prod      = numer_q * lfpd_pkg::RECIP_11;
    q0_x11    = {q0_q, 3'b000} + {3'b000, q0_q, 1'b0} + {4'b0000, q0_q};
    rem       = numer_q - q0_x11;
    ang_sum   = {2'b00, start_q} + {1'b0, quo_q};
    end_adj   = (start_q > end_q) ? ({1'b0, end_q} + lfpd_pkg::FULL_TURN) : {1'b0, end_q};
    slot_next = {1'b0, slot_q} + 11'(lfpd_pkg::POINTS_PER_FRAME);
    pt_dist   = {dhi_q, dlo_q};
    keep      = (pt_dist != 16'd0) && (ram_rdata > thr_q);
    frame_ok  = hdr_ok_q && len_ok_q && (crc_q == crc_byte_q);

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          ram_we  = 1'b1;
          count_d = count_q + AW'(1);
          if (count_q == LAST_BYTE) begin
            state_d = ST_SCAN;
            idx_d   = '0;
            crc_d   = 8'd0;
          end
        end
      end

      ST_SCAN: begin
        // read data belongs to the previous idx, as the RAM read is registered
        if (idx_q != '0) begin
          if (proc_idx != lfpd_pkg::OFS_CRC) begin
            crc_d = lfpd_pkg::crc8_step(crc_q, ram_rdata);
          end
          case (proc_idx)
            lfpd_pkg::OFS_HEADER:    hdr_ok_d = (ram_rdata == header_q);
            lfpd_pkg::OFS_LENGTH:    len_ok_d = (ram_rdata == length_q);
            lfpd_pkg::OFS_SPEED:     speed_d[7:0]  = ram_rdata;
            lfpd_pkg::OFS_SPEED + 1: speed_d[15:8] = ram_rdata;
            lfpd_pkg::OFS_START:     start_d[7:0]  = ram_rdata;
            lfpd_pkg::OFS_START + 1: start_d[15:8] = ram_rdata;
            lfpd_pkg::OFS_END:       end_d[7:0]    = ram_rdata;
            lfpd_pkg::OFS_END + 1:   end_d[15:8]   = ram_rdata;
            lfpd_pkg::OFS_STAMP:     stamp_d[7:0]  = ram_rdata;
            lfpd_pkg::OFS_STAMP + 1: stamp_d[15:8] = ram_rdata;
            lfpd_pkg::OFS_CRC:       crc_byte_d    = ram_rdata;
            default: ;
          endcase
        end
        idx_d = idx_q + (AW+1)'(1);
        if (idx_q == SCAN_END) begin
          state_d = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (frame_ok) begin
          diff_d     = end_adj - {1'b0, start_q};
          span_neg_d = (end_adj < {1'b0, start_q});
          wrapped_d  = (slot_next >= {1'b0, ppr_q});
          numer_d    = '0;
          m_d        = '0;
          pos_d      = lfpd_pkg::OFS_POINT0;
          ph_d       = 2'd0;
          state_d    = ST_POINT;
        end else begin
          // slide the window by one byte
          head_d  = wrap_addr(head_q, (AW+1)'(1));
          count_d = LAST_BYTE;
          state_d = ST_IDLE;
        end
      end

      ST_POINT: begin
        ram_raddr = wrap_addr(head_q, {1'b0, pos_q} + (AW+1)'(ph_q == 2'd3 ? 2'd2 : ph_q));
        case (ph_q)
          2'd0: begin
            q0_d = prod[lfpd_pkg::RECIP_SHIFT+16:lfpd_pkg::RECIP_SHIFT];
            ph_d = 2'd1;
          end
          2'd1: begin
            dlo_d = ram_rdata;
            quo_d = (rem >= 21'd11) ? (q0_q + 17'd1) : q0_q;
            ph_d  = 2'd2;
          end
          2'd2: begin
            dhi_d = ram_rdata;
            if (ang_sum > {1'b0, lfpd_pkg::FULL_TURN}) begin
              ang_sum = ang_sum - {1'b0, lfpd_pkg::FULL_TURN};
            end
            if (span_neg_q && (m_q != 4'd0)) begin
              // start leads end by more than a full turn: the span runs
              // backward and throws every later point far out, so saturate
              ang_d = 16'hFFFF;
            end else begin
              ang_d = (ang_sum > 18'd65535) ? 16'hFFFF : ang_sum[15:0];
            end
            ph_d  = 2'd3;
          end
          default: begin
            // hold until the output register is free
            if (out_free) begin
              out_valid_d = 1'b1;
              out_data_d  = {6'd0, stamp_q, speed_q, slot_q + {6'd0, m_q},
                             keep ? ram_rdata : 8'd0, keep ? pt_dist : 16'd0, ang_q};
              out_last_d  = (m_q == LAST_PT);
              out_user_d  = (m_q == LAST_PT) && wrapped_q;
              if (m_q == LAST_PT) begin
                slot_d  = wrapped_q ? 10'd0 : slot_next[9:0];
                count_d = '0;
                head_d  = '0;
                state_d = ST_IDLE;
              end else begin
                m_d     = m_q + 4'd1;
                pos_d   = pos_q + AW'(3);
                numer_d = numer_q + {4'b0000, diff_q};
                ph_d    = 2'd0;
              end
            end
          end
        endcase
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      ph_q        <= '0;
      m_q         <= '0;
      crc_q       <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      ph_q        <= ph_d;
      m_q         <= m_d;
      crc_q       <= crc_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    hdr_ok_q   <= hdr_ok_d;
    len_ok_q   <= len_ok_d;
    crc_byte_q <= crc_byte_d;
    speed_q    <= speed_d;
    start_q    <= start_d;
    end_q      <= end_d;
    stamp_q    <= stamp_d;
    diff_q     <= diff_d;
    span_neg_q <= span_neg_d;
    numer_q    <= numer_d;
    q0_q       <= q0_d;
    quo_q      <= quo_d;
    dlo_q      <= dlo_d;
    dhi_q      <= dhi_d;
    ang_q      <= ang_d;
    wrapped_q  <= wrapped_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    out_user_q <= out_user_d;
  end

endmodule

// ===== rtl/lfpd_ram.sv =====
module lfpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = lfpd_pkg::FRAME_BYTES
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
